// ----- rtl/core/idalloc_pkg.sv -----
// ----------------------------------------------------------------------------
// idalloc_pkg
// Shared widths, operation and status codes, and the control/status bundles
// that join the identifier allocator's controller and datapath.
// ----------------------------------------------------------------------------
package idalloc_pkg;

  localparam int ID_W       = 16;
  localparam int FREE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(FREE_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int FRESH_W    = ID_W + 1;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;

  // Operation codes. The unused code behaves as a clear.
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the incoming transaction
    logic exec;        // first work cycle: reset scan state
    logic scan_start;  // read the bottom stack entry
    logic pop_rd;      // read the top stack entry
    logic scan_step;   // compare one entry, read the next
    logic finish;      // update state and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_alloc;
    logic op_release;
    logic rid_bad;     // zero or never issued
    logic full;
    logic empty;
    logic scan_last;   // the entry under compare is the top of the stack
    logic out_free;    // result register can take a new result
  } dp_sts_t;

endpackage

// ----- rtl/core/idalloc_dp.sv -----
// ----------------------------------------------------------------------------
// idalloc_dp
// Datapath: free stack memory, stack count, fresh counter, scan compare and
// the result register.
// ----------------------------------------------------------------------------
module idalloc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  idalloc_pkg::ctrl_cmd_t               cmd,
  output idalloc_pkg::dp_sts_t                 sts,
  input  logic [idalloc_pkg::OP_W-1:0]         in_op,
  input  logic [idalloc_pkg::ID_W-1:0]         in_rid,
  input  logic                                 cfg_we,
  input  logic [idalloc_pkg::ID_W-1:0]         cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [idalloc_pkg::ID_W-1:0]         out_id,
  output logic [idalloc_pkg::STATUS_W-1:0]     out_status
);

  logic [idalloc_pkg::ID_W-1:0]     mem [idalloc_pkg::FREE_DEPTH];
  logic [idalloc_pkg::ID_W-1:0]     rd_r;
  logic [idalloc_pkg::OP_W-1:0]     op_r;
  logic [idalloc_pkg::ID_W-1:0]     rid_r;
  logic [idalloc_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [idalloc_pkg::FRESH_W-1:0]  fresh_r, fresh_nxt;
  logic [idalloc_pkg::ADDR_W-1:0]   idx_r;
  logic                             hit_r;
  logic                             out_valid_r;
  logic [idalloc_pkg::ID_W-1:0]     out_id_r, out_id_nxt;
  logic [idalloc_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [idalloc_pkg::CNT_W-1:0]    count_m1;
  logic                             rd_en;
  logic [idalloc_pkg::ADDR_W-1:0]   rd_addr;
  logic                             wr_en;
  logic                             cmp_hit;

  assign count_m1 = count_r - idalloc_pkg::CNT_W'(1);
  assign cmp_hit  = (rd_r == rid_r);

  assign sts.op_alloc   = (op_r == idalloc_pkg::OP_ALLOC);
  assign sts.op_release = (op_r == idalloc_pkg::OP_RELEASE);
  assign sts.rid_bad    = (rid_r == '0) || ({1'b0, rid_r} >= fresh_r);
  assign sts.full       = (count_r == idalloc_pkg::CNT_W'(idalloc_pkg::FREE_DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.scan_last  = ({1'b0, idx_r} == count_m1);
  assign sts.out_free   = !out_valid_r || out_ready;

  // Read port: top of stack for a pop, bottom for a scan start, then upward.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.pop_rd) begin
      rd_en   = 1'b1;
      rd_addr = count_m1[idalloc_pkg::ADDR_W-1:0];
    end else if (cmd.scan_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.scan_step) begin
      rd_en   = 1'b1;
      rd_addr = idx_r + idalloc_pkg::ADDR_W'(1);
    end
  end

  // Result and state update for the finishing transaction.
  always_comb begin
    count_nxt      = count_r;
    fresh_nxt      = fresh_r;
    out_id_nxt     = '0;
    out_status_nxt = idalloc_pkg::ST_CLEARED;
    wr_en          = 1'b0;
    if (sts.op_alloc) begin
      if (!sts.empty) begin
        out_id_nxt     = rd_r;
        count_nxt      = count_m1;
        out_status_nxt = idalloc_pkg::ST_ALLOCATED;
      end else if (!fresh_r[idalloc_pkg::ID_W]) begin
        out_id_nxt     = fresh_r[idalloc_pkg::ID_W-1:0];
        fresh_nxt      = fresh_r + idalloc_pkg::FRESH_W'(1);
        out_status_nxt = idalloc_pkg::ST_ALLOCATED;
      end else begin
        out_status_nxt = idalloc_pkg::ST_EXHAUSTED;
      end
    end else if (sts.op_release) begin
      if (sts.rid_bad || hit_r || sts.full) begin
        out_status_nxt = idalloc_pkg::ST_IGNORED;
      end else begin
        wr_en          = 1'b1;
        count_nxt      = count_r + idalloc_pkg::CNT_W'(1);
        out_status_nxt = idalloc_pkg::ST_ACCEPTED;
      end
    end else begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      mem[count_r[idalloc_pkg::ADDR_W-1:0]] <= rid_r;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      rid_r <= in_rid;
    end
    if (cmd.exec) begin
      idx_r <= '0;
      hit_r <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + idalloc_pkg::ADDR_W'(1);
      hit_r <= hit_r | cmp_hit;
    end
    if (cmd.finish) begin
      out_id_r     <= out_id_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fresh_r     <= idalloc_pkg::FRESH_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        // Identifier zero is reserved, so a zero write loads one.
        fresh_r <= (cfg_wdata == '0) ? idalloc_pkg::FRESH_W'(1) : {1'b0, cfg_wdata};
      end else if (cmd.finish) begin
        fresh_r <= fresh_nxt;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_status = out_status_r;

endmodule

// ----- rtl/core/idalloc_ctrl.sv -----
// ----------------------------------------------------------------------------
// idalloc_ctrl
// Controller: sequences one transaction through decode, duplicate scan and
// result write-back.
// ----------------------------------------------------------------------------
module idalloc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  idalloc_pkg::dp_sts_t   sts,
  output idalloc_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   scan_go;

  // A release that passes the cheap checks and finds entries must scan them.
  assign scan_go = sts.op_release && !sts.rid_bad && !sts.full && !sts.empty;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (scan_go) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.pop_rd = sts.op_alloc && !sts.empty;
          state_nxt  = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/id_allocator_free_stack.sv -----
// ----------------------------------------------------------------------------
// id_allocator_free_stack
// Identifier allocator with a last-in first-out free stack and a fresh
// counter, built as a controller and a datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction carries an operation in in_tuser (allocate,
//   release or clear) and, for a release, the identifier in in_tdata. Every
//   transaction produces exactly one result transaction: the identifier
//   handed out in out_tdata (zero unless an allocate succeeded) and a
//   status code in out_tuser.
//   Allocate and clear go from acceptance through decode to the result
//   register. A release that must be checked against the stack also scans
//   the N stacked identifiers (at most 63, as a full stack is never
//   scanned): the duplicate check reads the stack one entry per cycle. The
//   block works on one transaction at a time.
//   The input is taken again as soon as the previous transaction has been
//   handed to the result register, so a stalled receiver holds one result
//   while the next transaction is accepted and worked on; that one then
//   waits until the result register is free.
//   Reset empties the free stack and loads the fresh counter with one.
//   A write on cfg_we loads the fresh counter with cfg_wdata (zero loads one)
//   and must only occur while the block is idle.
// ----------------------------------------------------------------------------
module id_allocator_free_stack (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] release_id
  input  logic [1:0]  in_tuser,   // [1:0] op
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] alloc_id
  output logic [2:0]  out_tuser,  // [2:0] status
  // First identifier register.
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  idalloc_pkg::ctrl_cmd_t cmd;
  idalloc_pkg::dp_sts_t   sts;

  idalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  idalloc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_rid     (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_id     (out_tdata),
    .out_status (out_tuser)
  );

endmodule

// ----- tb/tb_id_allocator_free_stack.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_id_allocator_free_stack
// Self-checking bench for the identifier allocator. A short table of directed
// transactions covers the corner cases. Several phases of random traffic
// follow, each under its own first identifier. Every result is compared with
// an in-bench prediction of the free stack and the fresh counter.
// ----------------------------------------------------------------------------
module tb_id_allocator_free_stack;

  // Local names for the shared widths and codes.
  localparam int ID_W       = idalloc_pkg::ID_W;
  localparam int FREE_DEPTH = idalloc_pkg::FREE_DEPTH;
  localparam int FRESH_W    = idalloc_pkg::FRESH_W;
  localparam int OP_W       = idalloc_pkg::OP_W;
  localparam int STATUS_W   = idalloc_pkg::STATUS_W;

  localparam logic [OP_W-1:0] OP_ALLOC   = idalloc_pkg::OP_ALLOC;
  localparam logic [OP_W-1:0] OP_RELEASE = idalloc_pkg::OP_RELEASE;
  localparam logic [OP_W-1:0] OP_CLEAR   = idalloc_pkg::OP_CLEAR;

  localparam logic [STATUS_W-1:0] ST_ALLOCATED = idalloc_pkg::ST_ALLOCATED;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = idalloc_pkg::ST_ACCEPTED;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = idalloc_pkg::ST_IGNORED;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = idalloc_pkg::ST_CLEARED;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = idalloc_pkg::ST_EXHAUSTED;

  // The fourth operation code has no name in the package; it acts as a clear.
  localparam logic [OP_W-1:0]    OP_SPARE    = 2'd3;
  localparam logic [FRESH_W-1:0] COUNTER_TOP = FRESH_W'(1) << ID_W;
  localparam int                 RANDOM_ITEMS = 1950;
  localparam int                 IDLE_PCT     = 6;

  // One expected result: the identifier handed out and the status code.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] st;
  } grant_t;

  // One row of the directed table. When set_cfg is high, the bench drains
  // the block and writes cfg_val before it sends the transaction. When typed
  // is high, the expected result is taken from the row, not from the
  // prediction.
  typedef struct packed {
    logic                set_cfg;
    logic [ID_W-1:0]     cfg_val;
    logic [OP_W-1:0]     op;
    logic [ID_W-1:0]     rid;
    logic                typed;
    logic [ID_W-1:0]     want_id;
    logic [STATUS_W-1:0] want_st;
  } dir_row_t;

  // Traffic mixes for the random phases.
  typedef enum int {MIX_NORMAL, MIX_FILL, MIX_EXHAUST} mix_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // After reset the fresh counter starts at one.
    '{1'b0, 16'h0000, OP_ALLOC,   16'h0000, 1'b1, 16'h0001, ST_ALLOCATED},
    '{1'b0, 16'h0000, OP_ALLOC,   16'h0000, 1'b1, 16'h0002, ST_ALLOCATED},
    // Identifier zero is reserved and never taken back.
    '{1'b0, 16'h0000, OP_RELEASE, 16'h0000, 1'b1, 16'h0000, ST_IGNORED},
    // Identifiers at or above the fresh counter were never issued.
    '{1'b0, 16'h0000, OP_RELEASE, 16'h0003, 1'b1, 16'h0000, ST_IGNORED},
    '{1'b0, 16'h0000, OP_RELEASE, 16'hFFFF, 1'b1, 16'h0000, ST_IGNORED},
    '{1'b0, 16'h0000, OP_RELEASE, 16'h0001, 1'b1, 16'h0000, ST_ACCEPTED},
    // A second release of the same identifier is caught by the stack scan.
    '{1'b0, 16'h0000, OP_RELEASE, 16'h0001, 1'b1, 16'h0000, ST_IGNORED},
    '{1'b0, 16'h0000, OP_RELEASE, 16'h0002, 1'b1, 16'h0000, ST_ACCEPTED},
    // Allocation pops the most recent release first.
    '{1'b0, 16'h0000, OP_ALLOC,   16'h0000, 1'b1, 16'h0002, ST_ALLOCATED},
    '{1'b0, 16'h0000, OP_ALLOC,   16'h0000, 1'b1, 16'h0001, ST_ALLOCATED},
    '{1'b0, 16'h0000, OP_ALLOC,   16'h0000, 1'b1, 16'h0003, ST_ALLOCATED},
    '{1'b0, 16'h0000, OP_RELEASE, 16'h0002, 1'b0, 16'h0000, ST_ACCEPTED},
    '{1'b0, 16'h0000, OP_CLEAR,   16'h0000, 1'b1, 16'h0000, ST_CLEARED},
    '{1'b0, 16'h0000, OP_ALLOC,   16'h0000, 1'b0, 16'h0000, ST_ALLOCATED},
    '{1'b0, 16'h0000, OP_RELEASE, 16'h0004, 1'b0, 16'h0000, ST_ACCEPTED},
    // The spare operation code behaves as a clear.
    '{1'b0, 16'h0000, OP_SPARE,   16'hFFFF, 1'b1, 16'h0000, ST_CLEARED},
    // Top of the identifier range: one fresh identifier, then exhaustion.
    '{1'b1, 16'hFFFF, OP_ALLOC,   16'h0000, 1'b1, 16'hFFFF, ST_ALLOCATED},
    '{1'b0, 16'h0000, OP_ALLOC,   16'h0000, 1'b1, 16'h0000, ST_EXHAUSTED},
    '{1'b0, 16'h0000, OP_RELEASE, 16'hFFFF, 1'b1, 16'h0000, ST_ACCEPTED},
    '{1'b0, 16'h0000, OP_ALLOC,   16'h0000, 1'b1, 16'hFFFF, ST_ALLOCATED},
    '{1'b0, 16'h0000, OP_ALLOC,   16'h0000, 1'b1, 16'h0000, ST_EXHAUSTED},
    '{1'b0, 16'h0000, OP_RELEASE, 16'hAAAA, 1'b0, 16'h0000, ST_ACCEPTED},
    '{1'b0, 16'h0000, OP_ALLOC,   16'h0000, 1'b0, 16'h0000, ST_ALLOCATED},
    // Writing zero to the first identifier loads one instead.
    '{1'b1, 16'h0000, OP_ALLOC,   16'h5555, 1'b1, 16'h0001, ST_ALLOCATED}
  };

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [ID_W-1:0]     in_tdata   = '0;   // [15:0] release_id
  logic [OP_W-1:0]     in_tuser   = OP_ALLOC;  // [1:0] op
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [ID_W-1:0]     out_tdata;  // [15:0] alloc_id
  logic [STATUS_W-1:0] out_tuser;  // [2:0] status
  logic                cfg_we     = 1'b0;
  logic [ID_W-1:0]     cfg_wdata  = '0;

  // Predicted allocator state.
  logic [ID_W-1:0]    first_id_q;
  logic [FRESH_W-1:0] fresh_ctr;
  logic [ID_W-1:0]    stack_mem [FREE_DEPTH];
  int unsigned        stack_depth;

  grant_t          expected_grants [$];  // results still owed by the block
  logic [ID_W-1:0] held_ids [$];         // identifiers out in the field
  int              error_count = 0;
  bit              calm = 1'b0;          // no idling on either side when set

  id_allocator_free_stack u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A hard ceiling on the run. A correct run needs only a fraction of it.
  initial begin
    #4000000;
    $display("tb_id_allocator_free_stack: errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Advances the predicted state by one transaction and returns the result
  // that the block should produce for it.
  function automatic void allocator_step(input logic [OP_W-1:0] op,
                                         input logic [ID_W-1:0] rid,
                                         output grant_t res);
    bit dup;
    dup    = 1'b0;
    res.id = '0;
    case (op)
      OP_ALLOC: begin
        if (stack_depth > 0) begin
          stack_depth--;
          res.id = stack_mem[stack_depth];
          res.st = ST_ALLOCATED;
        end else if (fresh_ctr < COUNTER_TOP) begin
          res.id    = fresh_ctr[ID_W-1:0];
          fresh_ctr = fresh_ctr + FRESH_W'(1);
          res.st    = ST_ALLOCATED;
        end else begin
          // The counter has saturated and nothing is stacked.
          res.st = ST_EXHAUSTED;
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < stack_depth; i++) begin
          if (stack_mem[i] == rid) dup = 1'b1;
        end
        if (rid == '0 || {1'b0, rid} >= fresh_ctr || dup || stack_depth >= FREE_DEPTH) begin
          res.st = ST_IGNORED;
        end else begin
          stack_mem[stack_depth] = rid;
          stack_depth++;
          res.st = ST_ACCEPTED;
        end
      end
      default: begin
        // Clear and the spare code both drop the whole stack.
        stack_depth = 0;
        res.st      = ST_CLEARED;
      end
    endcase
  endfunction

  // Offers one transaction, waits for the handshake, and queues the result
  // that it must produce. The sender may idle for a few cycles first.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] rid,
                              input logic typed, input grant_t typed_res);
    grant_t res;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= rid;
    do @(posedge clk); while (!in_tready);
    allocator_step(op, rid, res);
    if (typed) res = typed_res;
    if (res.st == ST_ALLOCATED) begin
      held_ids = {held_ids, res.id};
      if (held_ids.size() > 256) void'(held_ids.pop_front());
    end
    expected_grants = {expected_grants, res};
  endtask

  // The first identifier may only change while the block is idle: every
  // owed result must have come back, plus a short settling pause.
  task automatic load_first_id(input logic [ID_W-1:0] value);
    in_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    first_id_q  = (value == '0) ? ID_W'(1) : value;
    fresh_ctr   = {1'b0, first_id_q};
  endtask

  // Picks one random transaction from the current state. Some releases are
  // identifiers that were really handed out, so the stack gets deep; the rest
  // are stray, duplicate, zero or just-out-of-range values.
  task automatic pick_request(input mix_t mix, output logic [OP_W-1:0] op,
                              output logic [ID_W-1:0] rid);
    int roll;
    int alloc_pct;
    int stray_pct;
    int slot;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:    begin alloc_pct = 10; stray_pct = 57; end
      MIX_EXHAUST: begin alloc_pct = 58; stray_pct = 7;  end
      default:     begin alloc_pct = 45; stray_pct = 20; end
    endcase
    op  = OP_RELEASE;
    rid = '0;
    if (roll < alloc_pct) begin
      op = OP_ALLOC;
    end else if (roll < alloc_pct + 25 && held_ids.size() != 0) begin
      slot = $urandom_range(held_ids.size() - 1);
      rid  = held_ids[slot];
      held_ids.delete(slot);
    end else if (roll < alloc_pct + 25 + stray_pct) begin
      if ($urandom_range(1)) rid = ID_W'($urandom_range(65535));
      else                   rid = ID_W'($urandom_range(1, fresh_ctr));
    end else if (roll < alloc_pct + 29 + stray_pct) begin
      if (stack_depth != 0) rid = stack_mem[$urandom_range(stack_depth - 1)];
      else                  op  = OP_ALLOC;
    end else if (roll < alloc_pct + 31 + stray_pct) begin
      rid = '0;
    end else if (roll < alloc_pct + 33 + stray_pct) begin
      // Exactly the next fresh identifier, which was never issued.
      rid = fresh_ctr[ID_W-1:0];
    end else begin
      op  = $urandom_range(1) ? OP_CLEAR : OP_SPARE;
      rid = ID_W'($urandom_range(65535));
    end
  endtask

  // Result side: random back-pressure, and a check of every result
  // transaction against the oldest owed result.
  always @(posedge clk) begin : result_check
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("result with none owed: id %h status %0d",
                                  out_tdata, out_tuser));
      end else begin
        want = expected_grants.pop_front();
        if (out_tdata !== want.id)
          report_mismatch($sformatf("alloc_id %h, expected %h", out_tdata, want.id));
        if (out_tuser !== want.st)
          report_mismatch($sformatf("status %0d, expected %0d", out_tuser, want.st));
      end
    end
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin : stimulus
    grant_t          row_res;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] rid;
    logic [ID_W-1:0] cfg_val;
    mix_t            mix;
    int              sent;
    int              phase;
    int              phase_len;

    // The block resets to a first identifier of one with an empty stack.
    first_id_q  = ID_W'(1);
    fresh_ctr   = FRESH_W'(1);
    stack_depth = 0;
    sent        = 0;
    phase       = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].set_cfg) load_first_id(DIRECTED[r].cfg_val);
      row_res.id = DIRECTED[r].want_id;
      row_res.st = DIRECTED[r].want_st;
      send_request(DIRECTED[r].op, DIRECTED[r].rid, DIRECTED[r].typed, row_res);
    end

    // Random phases. Each one loads its own first identifier; the rotation
    // covers one, zero, the top value, small and random values, and values
    // close to the top so that the counter runs out within the phase.
    while (sent < RANDOM_ITEMS) begin
      case (phase % 7)
        0:       begin cfg_val = ID_W'(1);                              mix = MIX_NORMAL;  end
        1:       begin cfg_val = ID_W'($urandom_range(2, 200));         mix = MIX_NORMAL;  end
        2:       begin cfg_val = ID_W'($urandom_range(16'h8000, 16'hFFFF)); mix = MIX_FILL; end
        3:       begin cfg_val = 16'hFFE0 + ID_W'($urandom_range(31));  mix = MIX_EXHAUST; end
        4:       begin cfg_val = '0;                                    mix = MIX_NORMAL;  end
        5:       begin cfg_val = 16'hFFFF;                              mix = MIX_FILL;    end
        default: begin cfg_val = ID_W'($urandom_range(65535));          mix = MIX_NORMAL;  end
      endcase
      load_first_id(cfg_val);
      phase_len = $urandom_range(120, 260);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        // A long stretch in the middle of the run with no idling at all.
        calm = (sent >= 700 && sent < 1000);
        pick_request(mix, op, rid);
        send_request(op, rid, 1'b0, row_res);
        sent++;
      end
      phase++;
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up.
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_id_allocator_free_stack: clean");
    end else begin
      $display("tb_id_allocator_free_stack: errors");
    end
    $finish;
  end

endmodule
